// ===== design/model_basis_from_direction_core_assert.svh =====
// Assertion macros used by the look-at basis normalizer, mbd_unit.
`ifndef MODEL_BASIS_FROM_DIRECTION_CORE_ASSERT_SVH
`define MODEL_BASIS_FROM_DIRECTION_CORE_ASSERT_SVH

// Checks that cond holds in the same cycle whenever trig holds.
`define MBD_CHECK_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Checks that cond holds in the cycle after trig holds.
`define MBD_CHECK_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== design/mbd_pkg.sv =====
// Shared constants and channel payload types for the look-at basis core.
package mbd_pkg;

  localparam int VEC_FRAC_BITS_DEF = 14;

  localparam int POS_W  = 32;
  localparam int VEC_W  = 16;
  localparam int AXIS_W = 16;

  // Normalization brings the largest magnitude into [2^14, 2^15).
  localparam int NORM_MSB    = 14;
  localparam int NORM_W      = 15;
  localparam int SUM_W       = 2 * NORM_W + 2;
  localparam int SQ_IN_SHIFT = 16;
  localparam int XW          = SUM_W + SQ_IN_SHIFT;
  localparam int SQRT_W      = XW / 2;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VEC_W-1:0] dir_x;
    logic signed [VEC_W-1:0] dir_y;
    logic signed [VEC_W-1:0] dir_z;
    logic signed [VEC_W-1:0] up_x;
    logic signed [VEC_W-1:0] up_y;
    logic signed [VEC_W-1:0] up_z;
  } cmd_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] side_x;
    logic signed [AXIS_W-1:0] side_y;
    logic signed [AXIS_W-1:0] side_z;
    logic signed [AXIS_W-1:0] fwd_x;
    logic signed [AXIS_W-1:0] fwd_y;
    logic signed [AXIS_W-1:0] fwd_z;
    logic signed [AXIS_W-1:0] third_x;
    logic signed [AXIS_W-1:0] third_y;
    logic signed [AXIS_W-1:0] third_z;
    logic signed [POS_W-1:0]  trans_x;
    logic signed [POS_W-1:0]  trans_y;
    logic signed [POS_W-1:0]  trans_z;
  } res_t;

endpackage

// ===== design/mbd_chan_if.sv =====
// Valid/ready channel carrying one payload item per transfer.
interface mbd_chan_if #(
  parameter type T = mbd_pkg::cmd_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/mbd_unit.sv =====
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
`include "model_basis_from_direction_core_assert.svh"

module mbd_unit #(
  parameter int IW   = 17,
  parameter int SW   = 1,
  parameter int FRAC = mbd_pkg::VEC_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0][IW-1:0]    in_vec,
  input  logic [SW-1:0]         in_side,
  output logic                  out_valid,
  output logic [2:0][FRAC+1:0]  out_vec,
  output logic [SW-1:0]         out_side
);
  import mbd_pkg::*;

  localparam int POS_W2 = $clog2(IW);
  localparam int WIDE_W = IW + NORM_W;
  localparam int OW     = FRAC + 2;
  localparam int QB     = FRAC + 1;
  localparam int ND     = NORM_W + FRAC + 9;
  localparam int CW     = SW + 4 + 3 * NORM_W;
  localparam int DW     = SW + 4;
  localparam logic [QB-1:0] QLIM = QB'(1) << FRAC;
  localparam logic signed [OW-1:0] SLIM = OW'(1) << FRAC;

  // Stage 1: magnitudes and signs.
  logic                  v1;
  logic [2:0][IW-1:0]    mag1;
  logic [2:0]            neg1;
  logic [SW-1:0]         side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= in_vec[i][IW-1];
        mag1[i] <= in_vec[i][IW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
      end
      side1 <= in_side;
    end
  end

  // Stage 2: leading one of the largest magnitude. The OR of the three
  // magnitudes has the same leading one as their maximum.
  logic [IW-1:0]         orv;
  logic [POS_W2-1:0]     lead;
  logic                  v2;
  logic [POS_W2-1:0]     lead2;
  logic                  zero2;
  logic [2:0][IW-1:0]    mag2;
  logic [2:0]            neg2;
  logic [SW-1:0]         side2;

  always_comb begin
    orv  = mag1[0] | mag1[1] | mag1[2];
    lead = '0;
    for (int b = 0; b < IW; b++) begin
      if (orv[b]) begin
        lead = POS_W2'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lead2 <= lead;
      zero2 <= (orv == '0);
      mag2  <= mag1;
      neg2  <= neg1;
      side2 <= side1;
    end
  end

  // Stage 3: shift all magnitudes by the same amount.
  logic [2:0][WIDE_W-1:0] wide3;
  logic                   v3;
  logic [2:0][NORM_W-1:0] m3;
  logic                   zero3;
  logic [2:0]             neg3;
  logic [SW-1:0]          side3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (lead2 >= POS_W2'(NORM_MSB)) begin
        wide3[i] = WIDE_W'(mag2[i]) >> (lead2 - POS_W2'(NORM_MSB));
      end else begin
        wide3[i] = WIDE_W'(mag2[i]) << (POS_W2'(NORM_MSB) - lead2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m3[i] <= wide3[i][NORM_W-1:0];
      end
      zero3 <= zero2;
      neg3  <= neg2;
      side3 <= side2;
    end
  end

  // Stage 4: squares. Stage 5: their sum.
  logic                     v4;
  logic [2:0][2*NORM_W-1:0] sq4;
  logic [2:0][NORM_W-1:0]   m4;
  logic                     zero4;
  logic [2:0]               neg4;
  logic [SW-1:0]            side4;
  logic                     v5;
  logic [SUM_W-1:0]         n5;
  logic [2:0][NORM_W-1:0]   m5;
  logic                     zero5;
  logic [2:0]               neg5;
  logic [SW-1:0]            side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= m3[i] * m3[i];
      end
      m4    <= m3;
      zero4 <= zero3;
      neg4  <= neg3;
      side4 <= side3;
      n5    <= SUM_W'(sq4[0]) + SUM_W'(sq4[1]) + SUM_W'(sq4[2]);
      m5    <= m4;
      zero5 <= zero4;
      neg5  <= neg4;
      side5 <= side4;
    end
  end

  // Square root, one result bit per stage, remainder form.
  logic              sv    [SQRT_W+1];
  logic [XW-1:0]     srem  [SQRT_W+1];
  logic [SQRT_W-1:0] sroot [SQRT_W+1];
  logic [CW-1:0]     scar  [SQRT_W+1];

  assign sv[0]    = v5;
  assign srem[0]  = {n5, {SQ_IN_SHIFT{1'b0}}};
  assign sroot[0] = '0;
  assign scar[0]  = {side5, zero5, neg5, m5};

  for (genvar k = 0; k < SQRT_W; k++) begin : g_root
    localparam int B = SQRT_W - 1 - k;
    logic [XW-1:0] trial;

    assign trial = (XW'(sroot[k]) << (B + 1)) | (XW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (en) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (srem[k] >= trial) begin
          srem[k+1]  <= srem[k] - trial;
          sroot[k+1] <= sroot[k] | (SQRT_W'(1) << B);
        end else begin
          srem[k+1]  <= srem[k];
          sroot[k+1] <= sroot[k];
        end
        scar[k+1] <= scar[k];
      end
    end
  end

  logic [SQRT_W-1:0]      s_fin;
  logic [SW-1:0]          side_s;
  logic                   zero_s;
  logic [2:0]             neg_s;
  logic [2:0][NORM_W-1:0] m_s;

  assign s_fin = sroot[SQRT_W];
  assign {side_s, zero_s, neg_s, m_s} = scar[SQRT_W];

  // Rounded division, one quotient bit per stage.
  logic                  dv   [QB+1];
  logic [2:0][ND-1:0]    drem [QB+1];
  logic [2:0][QB-1:0]    dq   [QB+1];
  logic [SQRT_W-1:0]     dsr  [QB+1];
  logic [DW-1:0]         dcar [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= sv[SQRT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= (ND'(m_s[i]) << (FRAC + 8)) + ND'(s_fin >> 1);
      end
      dq[0]   <= '0;
      dsr[0]  <= s_fin;
      dcar[0] <= {side_s, zero_s, neg_s};
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic [ND-1:0] dvs;

    assign dvs = ND'(dsr[j]) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1] <= 1'b0;
      end else if (en) begin
        dv[j+1] <= dv[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (drem[j][i] >= dvs) begin
            drem[j+1][i] <= drem[j][i] - dvs;
            dq[j+1][i]   <= dq[j][i] | (QB'(1) << B);
          end else begin
            drem[j+1][i] <= drem[j][i];
            dq[j+1][i]   <= dq[j][i];
          end
        end
        dsr[j+1]  <= dsr[j];
        dcar[j+1] <= dcar[j];
      end
    end
  end

  // Output stage: clamp, sign, and the zero-length case.
  logic [SW-1:0]      side_f;
  logic               zero_f;
  logic [2:0]         neg_f;
  logic [2:0][QB-1:0] qc;

  assign {side_f, zero_f, neg_f} = dcar[QB];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dq[QB][i] > QLIM) ? QLIM : dq[QB][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_f) begin
          out_vec[i] <= '0;
        end else if (neg_f[i]) begin
          out_vec[i] <= -OW'(qc[i]);
        end else begin
          out_vec[i] <= OW'(qc[i]);
        end
      end
      out_side <= side_f;
    end
  end

  // Per-component terms gathered for the checks below.
  logic rem_ok;
  logic range_ok;

  always_comb begin
    rem_ok   = 1'b1;
    range_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (drem[QB][i] >= ND'(dsr[QB])) begin
        rem_ok = 1'b0;
      end
      if (($signed(out_vec[i]) > SLIM) || ($signed(out_vec[i]) < -SLIM)) begin
        range_ok = 1'b0;
      end
    end
  end

  `MBD_CHECK_NOW(a_root_floor, sv[SQRT_W], srem[SQRT_W] <= (XW'(s_fin) << 1), "root not floor")
  `MBD_CHECK_NOW(a_div_rem, dv[QB] && !zero_f, rem_ok, "division remainder too large")
  `MBD_CHECK_NOW(a_unit_range, out_valid, range_ok, "axis out of range")
  `MBD_CHECK_NEXT(a_stall_hold, !en, $stable(out_valid) && $stable(out_vec), "output moved in stall")

endmodule

// ===== design/model_basis_from_direction_core.sv =====
// Look-at basis core: forward, side and third axes plus translation row.
//
//   channel  role    payload                        transfer when
//   -------  ------  -----------------------------  -------------------
//   cmd      sink    pos, dir, up                   cmd.valid & cmd.ready
//   res      source  side, fwd, third, trans rows   res.valid & res.ready
//
// One item is taken every cycle while res is not stalled; nothing depends on an earlier item.
// The path runs through three normalizers in series, each with a 24-stage
// square root and a (VEC_FRAC_BITS + 1)-stage divider, plus two cross-product
// stages after each of the first two normalizers.
// Reset is synchronous and clears only the valid bits; no clearing pass.
// A stall on res freezes the whole pipeline, so cmd.ready drops with it.
module model_basis_from_direction_core #(
  parameter int VEC_FRAC_BITS = mbd_pkg::VEC_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  mbd_chan_if.sink    cmd,
  mbd_chan_if.source  res
);
  import mbd_pkg::*;

  localparam int OW   = VEC_FRAC_BITS + 2;
  localparam int IW1  = VEC_W + 1;
  localparam int PW1  = OW + VEC_W;
  localparam int IW2  = PW1 + 1;
  localparam int PW2  = 2 * OW;
  localparam int IW3  = PW2 + 1;
  localparam int POS3 = 3 * POS_W;
  localparam int SW1  = POS3 + 3 * VEC_W;
  localparam int SW2  = POS3 + 3 * OW;
  localparam int SW3  = POS3 + 6 * OW;

  // The whole pipeline advances together whenever the output register
  // is empty or its item is being taken this cycle.
  logic adv;

  assign adv       = !res.valid || res.ready;
  assign cmd.ready = adv;

  // Forward axis input is the negated direction, widened so that the most
  // negative direction value still has a positive counterpart.
  logic [2:0][IW1-1:0]   dir_ext;
  logic [2:0][IW1-1:0]   fwd_in;
  logic [2:0][POS_W-1:0] pos_in;
  logic [2:0][VEC_W-1:0] up_in;

  always_comb begin
    dir_ext[0] = {cmd.data.dir_x[VEC_W-1], cmd.data.dir_x};
    dir_ext[1] = {cmd.data.dir_y[VEC_W-1], cmd.data.dir_y};
    dir_ext[2] = {cmd.data.dir_z[VEC_W-1], cmd.data.dir_z};
    for (int i = 0; i < 3; i++) begin
      fwd_in[i] = ~dir_ext[i] + 1'b1;
    end
    pos_in[0] = cmd.data.pos_x;
    pos_in[1] = cmd.data.pos_y;
    pos_in[2] = cmd.data.pos_z;
    up_in[0]  = cmd.data.up_x;
    up_in[1]  = cmd.data.up_y;
    up_in[2]  = cmd.data.up_z;
  end

  // First normalizer: forward axis, with position and up riding along.
  logic                  v_a;
  logic [2:0][OW-1:0]    fwd_a;
  logic [SW1-1:0]        side_a;
  logic [2:0][POS_W-1:0] pos_a;
  logic [2:0][VEC_W-1:0] up_a;

  mbd_unit #(
    .IW   (IW1),
    .SW   (SW1),
    .FRAC (VEC_FRAC_BITS)
  ) u_norm_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (cmd.valid),
    .in_vec    (fwd_in),
    .in_side   ({pos_in, up_in}),
    .out_valid (v_a),
    .out_vec   (fwd_a),
    .out_side  (side_a)
  );

  assign {pos_a, up_a} = side_a;

  // Cross product forward x up: products in one stage, differences next.
  logic                   vp1;
  logic signed [PW1-1:0]  pr1 [6];
  logic [2:0][POS_W-1:0]  pos_p1;
  logic [2:0][OW-1:0]     fwd_p1;
  logic                   vc1;
  logic [2:0][IW2-1:0]    cr1;
  logic [2:0][POS_W-1:0]  pos_c1;
  logic [2:0][OW-1:0]     fwd_c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp1 <= 1'b0;
      vc1 <= 1'b0;
    end else if (adv) begin
      vp1 <= v_a;
      vc1 <= vp1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr1[0] <= $signed(fwd_a[1]) * $signed(up_a[2]);
      pr1[1] <= $signed(fwd_a[2]) * $signed(up_a[1]);
      pr1[2] <= $signed(fwd_a[2]) * $signed(up_a[0]);
      pr1[3] <= $signed(fwd_a[0]) * $signed(up_a[2]);
      pr1[4] <= $signed(fwd_a[0]) * $signed(up_a[1]);
      pr1[5] <= $signed(fwd_a[1]) * $signed(up_a[0]);
      pos_p1 <= pos_a;
      fwd_p1 <= fwd_a;
      for (int k = 0; k < 3; k++) begin
        cr1[k] <= IW2'(pr1[2*k]) - IW2'(pr1[2*k+1]);
      end
      pos_c1 <= pos_p1;
      fwd_c1 <= fwd_p1;
    end
  end

  // Second normalizer: side axis.
  logic                  v_b;
  logic [2:0][OW-1:0]    side_b;
  logic [SW2-1:0]        band_b;
  logic [2:0][POS_W-1:0] pos_b;
  logic [2:0][OW-1:0]    fwd_b;

  mbd_unit #(
    .IW   (IW2),
    .SW   (SW2),
    .FRAC (VEC_FRAC_BITS)
  ) u_norm_side (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vc1),
    .in_vec    (cr1),
    .in_side   ({pos_c1, fwd_c1}),
    .out_valid (v_b),
    .out_vec   (side_b),
    .out_side  (band_b)
  );

  assign {pos_b, fwd_b} = band_b;

  // Cross product side x forward.
  logic                   vp2;
  logic signed [PW2-1:0]  pr2 [6];
  logic [2:0][POS_W-1:0]  pos_p2;
  logic [2:0][OW-1:0]     fwd_p2;
  logic [2:0][OW-1:0]     side_p2;
  logic                   vc2;
  logic [2:0][IW3-1:0]    cr2;
  logic [2:0][POS_W-1:0]  pos_c2;
  logic [2:0][OW-1:0]     fwd_c2;
  logic [2:0][OW-1:0]     side_c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp2 <= 1'b0;
      vc2 <= 1'b0;
    end else if (adv) begin
      vp2 <= v_b;
      vc2 <= vp2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr2[0]  <= $signed(side_b[1]) * $signed(fwd_b[2]);
      pr2[1]  <= $signed(side_b[2]) * $signed(fwd_b[1]);
      pr2[2]  <= $signed(side_b[2]) * $signed(fwd_b[0]);
      pr2[3]  <= $signed(side_b[0]) * $signed(fwd_b[2]);
      pr2[4]  <= $signed(side_b[0]) * $signed(fwd_b[1]);
      pr2[5]  <= $signed(side_b[1]) * $signed(fwd_b[0]);
      pos_p2  <= pos_b;
      fwd_p2  <= fwd_b;
      side_p2 <= side_b;
      for (int k = 0; k < 3; k++) begin
        cr2[k] <= IW3'(pr2[2*k]) - IW3'(pr2[2*k+1]);
      end
      pos_c2  <= pos_p2;
      fwd_c2  <= fwd_p2;
      side_c2 <= side_p2;
    end
  end

  // Third normalizer; its output register is the result register.
  logic                  v_c;
  logic [2:0][OW-1:0]    third_c;
  logic [SW3-1:0]        band_c;
  logic [2:0][POS_W-1:0] pos_c;
  logic [2:0][OW-1:0]    fwd_c;
  logic [2:0][OW-1:0]    side_c;

  mbd_unit #(
    .IW   (IW3),
    .SW   (SW3),
    .FRAC (VEC_FRAC_BITS)
  ) u_norm_third (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vc2),
    .in_vec    (cr2),
    .in_side   ({pos_c2, fwd_c2, side_c2}),
    .out_valid (v_c),
    .out_vec   (third_c),
    .out_side  (band_c)
  );

  assign {pos_c, fwd_c, side_c} = band_c;

  // Axis values carry their low 16 bits, sign-extended when the fraction
  // is narrow.
  assign res.valid        = v_c;
  assign res.data.side_x  = AXIS_W'($signed(side_c[0]));
  assign res.data.side_y  = AXIS_W'($signed(side_c[1]));
  assign res.data.side_z  = AXIS_W'($signed(side_c[2]));
  assign res.data.fwd_x   = AXIS_W'($signed(fwd_c[0]));
  assign res.data.fwd_y   = AXIS_W'($signed(fwd_c[1]));
  assign res.data.fwd_z   = AXIS_W'($signed(fwd_c[2]));
  assign res.data.third_x = AXIS_W'($signed(third_c[0]));
  assign res.data.third_y = AXIS_W'($signed(third_c[1]));
  assign res.data.third_z = AXIS_W'($signed(third_c[2]));
  assign res.data.trans_x = pos_c[0];
  assign res.data.trans_y = pos_c[1];
  assign res.data.trans_z = pos_c[2];

endmodule

// ===== test/model_basis_from_direction_core_tb.sv =====
// Self-checking testbench for the look-at basis core: directed table plus random stream.
`timescale 1ns / 1ps

module model_basis_from_direction_core_tb;
  import mbd_pkg::*;

  localparam int LATENCY    = 3 * (VEC_FRAC_BITS_DEF + 32) + 4;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM   = 1400;
  localparam int FRAC       = VEC_FRAC_BITS_DEF;

  logic clk;
  logic rst;

  mbd_chan_if #(.T(cmd_t)) cmd_ch ();
  mbd_chan_if #(.T(res_t)) res_ch ();

  model_basis_from_direction_core u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch.sink),
    .res (res_ch.source)
  );

  typedef struct {
    cmd_t cmd;
    bit   has_fixed;
    res_t fixed;
  } stim_row_t;

  typedef longint vec3_t[3];

  res_t      basis_q[$];
  stim_row_t stim_rows[$];
  int        fail_count;
  int        idle_cycles;
  bit        hold_off_req;

  // Clock with an 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Integer square root, floor, bit by bit.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Scale so the largest magnitude lands in [2^14, 2^15), then divide by the length.
  // A zero vector stays zero.
  function automatic vec3_t unit_vec(vec3_t v);
    vec3_t           u;
    longint unsigned mag[3];
    longint unsigned peak;
    longint unsigned sumsq;
    longint unsigned len;
    longint unsigned q;
    peak = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > peak) peak = mag[i];
    end
    if (peak == 0) begin
      u = '{0, 0, 0};
      return u;
    end
    while (peak >= (64'd1 << 15)) begin
      peak >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (peak < (64'd1 << 14)) begin
      peak <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    sumsq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    len   = int_sqrt(sumsq << 16);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << (FRAC + 8)) + (len >> 1)) / len;
      if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return u;
  endfunction

  function automatic vec3_t cross_vec(vec3_t a, vec3_t b);
    vec3_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  // Predicts the matrix rows for one command.
  function automatic res_t predict_basis(cmd_t c);
    vec3_t neg_dir, up, fwd, side, third;
    res_t  r;
    neg_dir = '{-longint'(c.dir_x), -longint'(c.dir_y), -longint'(c.dir_z)};
    up      = '{longint'(c.up_x), longint'(c.up_y), longint'(c.up_z)};
    fwd     = unit_vec(neg_dir);
    side    = unit_vec(cross_vec(fwd, up));
    third   = unit_vec(cross_vec(side, fwd));
    r.side_x  = side[0][15:0];
    r.side_y  = side[1][15:0];
    r.side_z  = side[2][15:0];
    r.fwd_x   = fwd[0][15:0];
    r.fwd_y   = fwd[1][15:0];
    r.fwd_z   = fwd[2][15:0];
    r.third_x = third[0][15:0];
    r.third_y = third[1][15:0];
    r.third_z = third[2][15:0];
    r.trans_x = c.pos_x;
    r.trans_y = c.pos_y;
    r.trans_z = c.pos_z;
    return r;
  endfunction

  function automatic cmd_t make_cmd(int px, int py, int pz, shortint dx, shortint dy,
                                    shortint dz, shortint ux, shortint uy, shortint uz);
    cmd_t c;
    c.pos_x = px;
    c.pos_y = py;
    c.pos_z = pz;
    c.dir_x = dx;
    c.dir_y = dy;
    c.dir_z = dz;
    c.up_x  = ux;
    c.up_y  = uy;
    c.up_z  = uz;
    return c;
  endfunction

  function automatic void add_row(cmd_t c);
    stim_row_t row;
    row.cmd       = c;
    row.has_fixed = 1'b0;
    stim_rows.push_back(row);
  endfunction

  // A row whose answer is obvious: all three axes given explicitly.
  function automatic void add_fixed(cmd_t c, shortint sx, shortint sy, shortint sz,
                                    shortint fx, shortint fy, shortint fz,
                                    shortint tx, shortint ty, shortint tz);
    stim_row_t row;
    row.cmd       = c;
    row.has_fixed = 1'b1;
    row.fixed     = '{sx, sy, sz, fx, fy, fz, tx, ty, tz, c.pos_x, c.pos_y, c.pos_z};
    stim_rows.push_back(row);
  endfunction

  function automatic shortint rand_vec16();
    case ($urandom_range(0, 5))
      0: return shortint'($urandom_range(0, 65535));
      1: return shortint'($urandom_range(0, 64)) - 16'sd32;
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return shortint'($urandom_range(0, 32767)) - 16'sd16384;
    endcase
  endfunction

  // Builds a random command; some set up to the direction arithmetic-shifted right
  // by one, and a few zero the direction or up vector.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   kind;
    c.pos_x = $urandom;
    c.pos_y = $urandom;
    c.pos_z = $urandom;
    c.dir_x = rand_vec16();
    c.dir_y = rand_vec16();
    c.dir_z = rand_vec16();
    c.up_x  = rand_vec16();
    c.up_y  = rand_vec16();
    c.up_z  = rand_vec16();
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      c.dir_x = '0;
      c.dir_y = '0;
      c.dir_z = '0;
    end else if (kind == 1) begin
      c.up_x = '0;
      c.up_y = '0;
      c.up_z = '0;
    end else if (kind == 2) begin
      c.up_x = c.dir_x >>> 1;
      c.up_y = c.dir_y >>> 1;
      c.up_z = c.dir_z >>> 1;
    end
    return c;
  endfunction

  function automatic void check_basis(res_t got, res_t want);
    if (got !== want) begin
      fail_count++;
      $display("%0t: basis mismatch expected side=(%0d %0d %0d) fwd=(%0d %0d %0d) third=(%0d %0d %0d) trans=(%0d %0d %0d)",
               $time, want.side_x, want.side_y, want.side_z, want.fwd_x, want.fwd_y,
               want.fwd_z, want.third_x, want.third_y, want.third_z, want.trans_x,
               want.trans_y, want.trans_z);
      $display("%0t: basis mismatch actual   side=(%0d %0d %0d) fwd=(%0d %0d %0d) third=(%0d %0d %0d) trans=(%0d %0d %0d)",
               $time, got.side_x, got.side_y, got.side_z, got.fwd_x, got.fwd_y,
               got.fwd_z, got.third_x, got.third_y, got.third_z, got.trans_x,
               got.trans_y, got.trans_z);
    end
  endfunction

  // Fills the directed table: axis-aligned views with known answers, zero and
  // parallel cases, and the field extremes.
  initial begin
    // Looking down -z with up +y: forward is +z, side is -x, third is +y.
    add_fixed(make_cmd(0, 0, 0, 0, 0, -16384, 0, 16384, 0),
              -16384, 0, 0, 0, 0, 16384, 0, 16384, 0);
    add_fixed(make_cmd(-1, 1, 32'h7fffffff, -16384, 0, 0, 0, 0, 16384),
              0, -16384, 0, 16384, 0, 0, 0, 0, 16384);
    // A zero direction zeroes every axis.
    add_fixed(make_cmd(32'h80000000, 32'h7fffffff, -5, 0, 0, 0, 100, -7, 3),
              0, 0, 0, 0, 0, 0, 0, 0, 0);
    // Zero up, or up parallel to the direction, zeroes side and third.
    add_fixed(make_cmd(12, 34, 56, 0, 16384, 0, 0, 0, 0),
              0, 0, 0, 0, -16384, 0, 0, 0, 0);
    add_fixed(make_cmd(7, 8, 9, 0, 0, 1, 0, 0, -32768),
              0, 0, 0, 0, 0, -16384, 0, 0, 0);
    add_row(make_cmd(1, 2, 3, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 0, 16'sh7fff));
    add_row(make_cmd(-1, -2, -3, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 0));
    add_row(make_cmd(0, 0, 0, 1, 0, 0, 0, 1, 0));
    add_row(make_cmd(0, 0, 0, -1, -1, 1, 1, -1, -1));
    add_row(make_cmd(0, 0, 0, 16'sh8000, 1, 0, 0, 0, 16'sh8000));
    add_row(make_cmd(-1, -1, -1, 3, 4, 0, 16'shffff, 16'shffff, 16'shffff));
    add_row(make_cmd(32'h55555555, 32'haaaaaaaa, 0, 16'sh5555, 16'shaaaa, 16'sh1234,
                     16'shaaaa, 16'sh5555, 16'shedcb));
    add_row(make_cmd(5, 5, 5, 16384, 16384, 1, 1, 16384, 16384));
    add_row(make_cmd(9, 9, 9, 100, -200, 300, -32768, 32767, 1));
  end

  // Receiver: random ready with short and occasional long stalls; one long
  // hold-off when the sender asks, counted here so the pipeline backs up.
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        for (int i = 0; i < 400; i++) @(posedge clk);
        hold_off_req = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1: stall = $urandom_range(1, 3);
        2: stall = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : 0;
        default: stall = 0;
      endcase
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Checker: each result transfer is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (basis_q.size() == 0) begin
        fail_count++;
        $display("%0t: basis mismatch expected no transfer, actual trans_x=%0d",
                 $time, res_ch.data.trans_x);
      end else begin
        check_basis(res_ch.data, basis_q.pop_front());
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("model_basis_from_direction_core: mismatch");
        $finish;
      end
    end
  end

  // Sends one command: holds valid until the transfer, then records the
  // prediction or the fixed answer. Leaves valid high for a following item.
  task automatic send_cmd(cmd_t c, bit has_fixed, res_t fixed);
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= c;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (has_fixed) begin
      // The typed-in answer must agree with the predictor as well.
      check_basis(predict_basis(c), fixed);
      basis_q.push_back(fixed);
    end else begin
      basis_q.push_back(predict_basis(c));
    end
  endtask

  task automatic sender_gap();
    int gap;
    case ($urandom_range(0, 9))
      0, 1: gap = $urandom_range(1, 3);
      2: gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100) : 0;
      default: gap = 0;
    endcase
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Main sequence: reset, directed table, random stream with a long receiver
  // hold-off and a pause until the pipeline drains, then the final wait.
  initial begin
    res_t no_fixed;
    int   wait_cycles;
    no_fixed     = '0;
    fail_count   = 0;
    hold_off_req = 1'b0;
    rst          = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.data  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      send_cmd(stim_rows[i].cmd, stim_rows[i].has_fixed, stim_rows[i].fixed);
      sender_gap();
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_off_req = 1'b1;
      if (n == 700) begin
        // Sender pauses until every outstanding result has arrived.
        cmd_ch.valid <= 1'b0;
        while (basis_q.size() != 0) @(posedge clk);
      end
      send_cmd(rand_cmd(), 1'b0, no_fixed);
      // Back-to-back stretches with no gaps at all.
      if (n < 100 || n > 1200 || (n % 200) >= 40) sender_gap();
    end
    cmd_ch.valid <= 1'b0;

    while (basis_q.size() != 0) @(posedge clk);
    wait_cycles = 0;
    while (wait_cycles < LATENCY + 20) begin
      @(posedge clk);
      wait_cycles++;
    end

    if (fail_count == 0) begin
      $display("model_basis_from_direction_core: match");
    end else begin
      $display("model_basis_from_direction_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/mbd_pkg.sv
design/mbd_chan_if.sv
design/mbd_unit.sv
design/model_basis_from_direction_core.sv
test/model_basis_from_direction_core_tb.sv
